@@ sv/bafq_pkg.sv @@
// Package: shared types, codes and field widths of the run allocator.
`timescale 1ns / 1ps

package bafq_pkg;

    // Field widths
    localparam int START_W  = 16;
    localparam int LEN_W    = 17;
    localparam int STATUS_W = 2;
    localparam int ENTRY_W  = LEN_W + START_W;

    // Default sizes
    localparam int MAX_SLOTS_DEF        = 65536;
    localparam int FREE_QUEUE_DEPTH_DEF = 16;

    // Request kinds
    localparam logic MODE_ALLOC = 1'b0;
    localparam logic MODE_FREE  = 1'b1;

    // Result status codes
    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK         = 2'd0,
        STATUS_OUT_OF_SPACE = 2'd1,
        STATUS_QUEUE_FULL = 2'd2
    } status_t;

    // Sequencer states
    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_EXEC = 1'b1
    } state_t;

endpackage

@@ sv/bump_allocator_with_free_fifo_top.sv @@
// Top level: run allocator with bump pointer and a queue of freed runs.
//
// Usage:
//   Requests arrive on the s_ stream. s_tuser[0] is the kind (0 allocate,
//   1 free); s_tdata carries run_length in bits 16:0 and run_start in
//   bits 32:17. Each request yields exactly one result word on the m_
//   stream: m_tdata[15:0] is the granted start, m_tuser[1:0] the status.
//   The slot limit is written on the cfg_ channel while no request is in
//   flight; it saturates at MAX_SLOTS.
// Timing:
//   The accept cycle issues a read of the oldest queued run from the queue
//   memory; in ST_EXEC, once the result register is free or being read out,
//   the request is decided, written back (shrunk head or pushed free) and
//   its result loaded into the result register, which drives m_tvalid. A
//   new request is taken only after the current one has been decided:
//   s_tready is high only in ST_IDLE.
// Reset and stall:
//   Reset empties the queue, clears the bump pointer and sets the limit
//   to MAX_SLOTS. While the result register waits on m_tready, one more
//   request may be accepted; it then holds in ST_EXEC until the
//   result register frees up.
`timescale 1ns / 1ps

module bump_allocator_with_free_fifo_top #(
    parameter int MAX_SLOTS        = bafq_pkg::MAX_SLOTS_DEF,
    parameter int FREE_QUEUE_DEPTH = bafq_pkg::FREE_QUEUE_DEPTH_DEF
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    // Request stream
    input  logic                    s_tvalid,
    output logic                    s_tready,
    input  logic [39:0]             s_tdata,   // run_length[16:0], run_start[32:17], zero pad
    input  logic [0:0]              s_tuser,   // mode[0]
    // Result stream
    output logic                    m_tvalid,
    input  logic                    m_tready,
    output logic [15:0]             m_tdata,   // granted_start[15:0]
    output logic [1:0]              m_tuser,   // status[1:0]
    // Slot limit write channel
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [bafq_pkg::LEN_W-1:0] cfg_data  // slot_limit[16:0]
);
    import bafq_pkg::*;

    localparam int PTR_W  = $clog2(FREE_QUEUE_DEPTH);
    localparam int FILL_W = $clog2(FREE_QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0]  LAST_PTR   = PTR_W'(FREE_QUEUE_DEPTH - 1);
    localparam logic [FILL_W-1:0] FULL_FILL  = FILL_W'(FREE_QUEUE_DEPTH);
    localparam logic [31:0]       MAX_SLOTS_W = MAX_SLOTS;

    // Queue memory: {length, start}
    logic [ENTRY_W-1:0] queue_mem [FREE_QUEUE_DEPTH];
    logic [ENTRY_W-1:0] rd_data_reg;
    logic               mem_we;
    logic [PTR_W-1:0]   mem_waddr;
    logic [ENTRY_W-1:0] mem_wdata;

    state_t             state_reg, state_next;
    logic [LEN_W-1:0]   limit_reg;
    logic [LEN_W-1:0]   bump_reg, bump_next;
    logic [PTR_W-1:0]   head_reg, head_next;
    logic [PTR_W-1:0]   tail_reg, tail_next;
    logic [FILL_W-1:0]  fill_reg, fill_next;

    // Latched request word
    logic               mode_reg;
    logic [LEN_W-1:0]   len_reg;
    logic [START_W-1:0] start_reg;

    // Result register
    logic               m_tvalid_reg, m_tvalid_next;
    logic [START_W-1:0] granted_reg, granted_next;
    status_t            status_reg, status_next;

    logic               s_accept;
    logic               exec_fire;
    logic [LEN_W-1:0]   eff_limit;
    logic [LEN_W:0]     bump_sum;
    logic               bump_fit;
    logic [LEN_W-1:0]   head_len;
    logic [START_W-1:0] head_start;

    assign s_accept  = s_tvalid && s_tready;
    assign exec_fire = (state_reg == ST_EXEC) && (!m_tvalid_reg || m_tready);
    assign cfg_ready = 1'b1;

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (s_accept) state_next = ST_EXEC;
            ST_EXEC: if (exec_fire) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // Handshake outputs
    always_comb begin
        case (state_reg)
            ST_IDLE: s_tready = 1'b1;
            default: s_tready = 1'b0;
        endcase
    end

    // Saturate the limit and form the bump sum at full width
    assign eff_limit  = ({15'd0, limit_reg} > MAX_SLOTS_W) ? MAX_SLOTS_W[LEN_W-1:0] : limit_reg;
    assign bump_sum   = {1'b0, bump_reg} + {1'b0, len_reg};
    assign bump_fit   = bump_sum <= {1'b0, eff_limit};
    assign head_len   = rd_data_reg[ENTRY_W-1:START_W];
    assign head_start = rd_data_reg[START_W-1:0];

    // Decide the request and update the allocator state
    always_comb begin
        bump_next     = bump_reg;
        head_next     = head_reg;
        tail_next     = tail_reg;
        fill_next     = fill_reg;
        mem_we        = 1'b0;
        mem_waddr     = tail_reg;
        mem_wdata     = {len_reg, start_reg};
        granted_next  = granted_reg;
        status_next   = status_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        if (exec_fire) begin
            m_tvalid_next = 1'b1;
            granted_next  = '0;
            status_next   = STATUS_OK;
            if (mode_reg == MODE_FREE) begin
                if (fill_reg == FULL_FILL) begin
                    status_next = STATUS_QUEUE_FULL;
                end else begin
                    mem_we    = 1'b1;
                    tail_next = (tail_reg == LAST_PTR) ? '0 : tail_reg + 1'b1;
                    fill_next = fill_reg + 1'b1;
                end
            end else if (bump_fit) begin
                granted_next = bump_reg[START_W-1:0];
                bump_next    = bump_sum[LEN_W-1:0];
            end else if (fill_reg != '0 && head_len >= len_reg) begin
                granted_next = head_start;
                if (head_len > len_reg) begin
                    // Shrink the oldest run from the front
                    mem_we    = 1'b1;
                    mem_waddr = head_reg;
                    mem_wdata = {head_len - len_reg, head_start + len_reg[START_W-1:0]};
                end else begin
                    head_next = (head_reg == LAST_PTR) ? '0 : head_reg + 1'b1;
                    fill_next = fill_reg - 1'b1;
                end
            end else begin
                status_next = STATUS_OUT_OF_SPACE;
            end
        end
    end

    // Queue memory: write back, read the head on accept
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            queue_mem[mem_waddr] <= mem_wdata;
        end
        if (s_accept) begin
            rd_data_reg <= queue_mem[head_reg];
        end
    end

    // Latch the request and hold the result payload
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            mode_reg  <= s_tuser[0];
            len_reg   <= s_tdata[LEN_W-1:0];
            start_reg <= s_tdata[LEN_W+START_W-1:LEN_W];
        end
        granted_reg <= granted_next;
        status_reg  <= status_next;
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            limit_reg    <= MAX_SLOTS_W[LEN_W-1:0];
            bump_reg     <= '0;
            head_reg     <= '0;
            tail_reg     <= '0;
            fill_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            bump_reg     <= bump_next;
            head_reg     <= head_next;
            tail_reg     <= tail_next;
            fill_reg     <= fill_next;
            m_tvalid_reg <= m_tvalid_next;
            if (cfg_valid && cfg_ready) begin
                limit_reg <= cfg_data;
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = granted_reg;
    assign m_tuser  = status_reg;

    // Fill count stays within the queue depth
    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= FULL_FILL)
        else $error("queue fill count exceeds depth");

    // Empty or full queue has head and tail on the same entry
    a_ptr_match: assert property (@(posedge aclk) disable iff (!aresetn)
        (fill_reg == '0 || fill_reg == FULL_FILL) |-> head_reg == tail_reg)
        else $error("queue pointers disagree with fill count");

    // An accepted request moves to the decide cycle
    a_accept_exec: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> state_reg == ST_EXEC)
        else $error("accepted request not executed");

    // A decided request always presents a result
    a_fire_result: assert property (@(posedge aclk) disable iff (!aresetn)
        exec_fire |=> m_tvalid_reg)
        else $error("decided request lost its result");

    // Memory write never coincides with a head read
    a_no_rw_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |-> !mem_we)
        else $error("queue write overlaps head read");

endmodule

@@ tb/tb_bump_allocator_with_free_fifo_top.sv @@
// Testbench for the run allocator: predicts every grant and checks the result stream.
`timescale 1ns / 1ps

module tb_bump_allocator_with_free_fifo_top;
    import bafq_pkg::*;

    localparam int CLK_HALF     = 10;
    localparam int DEPTH        = FREE_QUEUE_DEPTH_DEF;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int SETTLE_CYCLES = 8;
    localparam int SEG_ITEMS    = 109;
    localparam int LONG_HOLD    = 300;

    typedef struct {
        logic [START_W-1:0] start;
        status_t            status;
    } grant_t;

    logic                aclk      = 1'b0;
    logic                aresetn   = 1'b0;
    logic                s_tvalid  = 1'b0;
    logic                s_tready;
    logic [39:0]         s_tdata   = '0;
    logic [0:0]          s_tuser   = '0;
    logic                m_tvalid;
    logic                m_tready  = 1'b0;
    logic [15:0]         m_tdata;
    logic [1:0]          m_tuser;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [LEN_W-1:0]    cfg_data  = '0;

    // Predictor state
    logic [LEN_W-1:0]    limit_reg = LEN_W'(MAX_SLOTS_DEF);
    logic [LEN_W-1:0]    bump_ptr  = '0;
    logic [START_W-1:0]  fq_start [DEPTH];
    logic [LEN_W-1:0]    fq_len   [DEPTH];
    int                  fq_head   = 0;
    int                  fq_tail   = 0;
    int                  fq_fill   = 0;

    grant_t              pending_grants [$];
    int                  errors      = 0;
    int                  cycle_cnt   = 0;
    int                  tx_idle_pct = 0;
    int                  rx_idle_pct = 0;
    int                  hold_req    = 0;
    int                  hold_len    = 0;
    int                  hold_seen   = 0;
    int                  hold_left   = 0;
    bit                  req_idle    = 1'b1;

    bump_allocator_with_free_fifo_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #CLK_HALF aclk = ~aclk;

    // Compute the grant for one request and advance the allocator state
    function automatic void predict_grant(input logic mode, input logic [LEN_W-1:0] len,
                                          input logic [START_W-1:0] start, output grant_t g);
        int eff_limit;
        g.start  = '0;
        g.status = STATUS_OK;
        eff_limit = (int'(limit_reg) > MAX_SLOTS_DEF) ? MAX_SLOTS_DEF : int'(limit_reg);
        if (mode == MODE_FREE) begin
            if (fq_fill >= DEPTH) begin
                g.status = STATUS_QUEUE_FULL;
            end else begin
                fq_start[fq_tail] = start;
                fq_len[fq_tail]   = len;
                fq_tail = (fq_tail + 1) % DEPTH;
                fq_fill++;
            end
        end else if (int'(bump_ptr) + int'(len) <= eff_limit) begin
            g.start  = bump_ptr[START_W-1:0];
            bump_ptr = bump_ptr + len;
        end else if (fq_fill > 0 && fq_len[fq_head] >= len) begin
            g.start = fq_start[fq_head];
            if (fq_len[fq_head] > len) begin
                // shrink the head run from the front, start wraps at 16 bits
                fq_start[fq_head] = fq_start[fq_head] + len[START_W-1:0];
                fq_len[fq_head]   = fq_len[fq_head] - len;
            end else begin
                fq_head = (fq_head + 1) % DEPTH;
                fq_fill--;
            end
        end else begin
            g.status = STATUS_OUT_OF_SPACE;
        end
    endfunction

    // Pick a run length: mostly short, a few zero and a few huge
    function automatic logic [LEN_W-1:0] rand_len();
        int r;
        r = $urandom_range(99);
        if (r < 2)  return LEN_W'(MAX_SLOTS_DEF);
        if (r < 6)  return LEN_W'($urandom_range(65535));
        if (r < 12) return '0;
        return LEN_W'($urandom_range(200, 1));
    endfunction

    // Offer one request word, record its grant on accept, then maybe idle
    task automatic send_req(input logic mode, input logic [LEN_W-1:0] len,
                            input logic [START_W-1:0] start);
        grant_t g;
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= {7'b0, start, len};
        req_idle = 1'b0;
        do @(posedge aclk); while (!s_tready);
        predict_grant(mode, len, start, g);
        pending_grants.push_back(g);
        if ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            req_idle = 1'b1;
            repeat ($urandom_range(4, 1)) @(posedge aclk);
        end
    endtask

    // Drop valid unless a gap already did
    task automatic idle_stream();
        if (!req_idle) begin
            s_tvalid <= 1'b0;
            req_idle = 1'b1;
        end
    endtask

    // Write the slot limit once the block has drained
    task automatic write_limit(input logic [LEN_W-1:0] value);
        idle_stream();
        while (pending_grants.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        limit_reg = value;
    endtask

    // One random stretch under a given limit
    task automatic run_segment(input int n, input logic [LEN_W-1:0] value);
        int r;
        write_limit(value);
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(99);
            if (r < 48)
                send_req(MODE_ALLOC, rand_len(), START_W'($urandom));
            else if (r < 92)
                send_req(MODE_FREE, rand_len(), START_W'($urandom));
            else
                send_req(MODE_ALLOC, LEN_W'(MAX_SLOTS_DEF), START_W'($urandom));
        end
    endtask

    // Bump pointer to the top of the space, then past 16 bits
    task automatic test_bump_edge();
        send_req(MODE_ALLOC, '0, 16'hFFFF);
        send_req(MODE_ALLOC, LEN_W'(MAX_SLOTS_DEF), '0);
        send_req(MODE_ALLOC, '0, '0);
        send_req(MODE_ALLOC, 17'd1, '0);
    endtask

    // Shrink, exact pop, zero-length runs and a head that is too small
    task automatic test_free_queue();
        send_req(MODE_FREE, LEN_W'(MAX_SLOTS_DEF), 16'hFFFF);
        send_req(MODE_ALLOC, 17'd3, 16'h1234);
        send_req(MODE_ALLOC, 17'd65533, '0);
        send_req(MODE_FREE, '0, 16'h8000);
        send_req(MODE_ALLOC, 17'd1, '0);
        write_limit('0);
        send_req(MODE_ALLOC, '0, '0);
        send_req(MODE_ALLOC, 17'd5, '0);
    endtask

    // Fill the queue, overflow it once, then pop the head
    task automatic test_queue_full();
        for (int i = 0; i <= DEPTH; i++)
            send_req(MODE_FREE, LEN_W'(i + 1), START_W'(i * 4099));
        send_req(MODE_ALLOC, 17'd1, '0);
    endtask

    // Random traffic under three idling profiles and several limits
    task automatic test_random_traffic();
        for (int p = 0; p < 3; p++) begin
            tx_idle_pct = (p == 0) ? 11 : (p == 1) ? 58 : 0;
            rx_idle_pct = (p == 0) ? 58 : (p == 1) ? 11 : 0;
            run_segment(SEG_ITEMS, LEN_W'(MAX_SLOTS_DEF));
            run_segment(SEG_ITEMS, '0);
            run_segment(SEG_ITEMS, LEN_W'($urandom_range(MAX_SLOTS_DEF)));
        end
    endtask

    // Stall the result side for a long stretch while requests keep coming
    task automatic test_backpressure();
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        hold_len = LONG_HOLD;
        hold_req++;
        for (int i = 0; i < 40; i++)
            send_req(($urandom_range(1) != 0) ? MODE_FREE : MODE_ALLOC,
                     rand_len(), START_W'($urandom));
    endtask

    // Drive result-side ready, with an occasional long hold-off
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_seen != hold_req) begin
            hold_seen <= hold_req;
            hold_left <= hold_len;
            m_tready  <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // Compare each accepted result word with the oldest pending grant
    always @(posedge aclk) begin : result_check
        grant_t g;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_grants.size() == 0) begin
                $display("%0t: unexpected result start=%h status=%0d",
                         $time, m_tdata, m_tuser);
                errors++;
            end else begin
                g = pending_grants.pop_front();
                if (m_tdata !== g.start) begin
                    $display("%0t: granted_start expected %h actual %h",
                             $time, g.start, m_tdata);
                    errors++;
                end
                if (m_tuser !== g.status) begin
                    $display("%0t: status expected %0d actual %0d",
                             $time, g.status, m_tuser);
                    errors++;
                end
            end
        end
    end

    // Bound the run
    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_bump_edge();
        test_free_queue();
        test_queue_full();
        test_random_traffic();
        test_backpressure();
        idle_stream();
        while (pending_grants.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

@@ sim.f @@
sv/bafq_pkg.sv
sv/bump_allocator_with_free_fifo_top.sv
tb/tb_bump_allocator_with_free_fifo_top.sv
